// File: design/lee_adaptive_denoise_filter_core_assert.svh
// Assertion macros for the Lee filter core.
`ifndef LEE_ADAPTIVE_DENOISE_FILTER_CORE_ASSERT_SVH
`define LEE_ADAPTIVE_DENOISE_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LADF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define LADF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LADF_ASSERT(lbl, clk, rstn, prop, msg)
`define LADF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: design/ladf_pkg.sv
package ladf_pkg;

    localparam int MAX_HEIGHT = 4096;

    localparam logic [1:0] CFG_SIGMA        = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_THREE_CH     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SHIFT,
        S_ACC,
        S_START,
        S_CALC,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic acc_en;
        logic acc_first;
        logic start;
    } t_lane_ctl;

endpackage

// File: design/ladf_ram.sv
module ladf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/ladf_lane.sv
`include "lee_adaptive_denoise_filter_core_assert.svh"
module ladf_lane #(
    parameter int WINDOW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ladf_pkg::t_lane_ctl   i_ctl,
    input  logic [15:0]           i_sigma,
    input  logic [WINDOW*8-1:0]   i_row,
    input  logic [7:0]            i_centre,
    output logic                  o_done,
    output logic [7:0]            o_result
);
    import ladf_pkg::*;

    localparam longint AREA = WINDOW * WINDOW;
    localparam int NW   = $clog2(AREA + 1);
    localparam int SW   = $clog2(255 * AREA + 1);
    localparam int S2W  = $clog2(65025 * AREA + 1);
    localparam int VW   = NW + S2W;
    localparam int SNW  = 16 + NW;
    localparam int SNSW = SNW + SW;
    localparam int SNNW = SNW + NW;
    localparam int DENW = ((VW > SNNW) ? VW : SNNW) + 1;
    localparam int VCW  = VW + 8;
    localparam int NUMW = ((SNSW > VCW) ? SNSW : VCW) + 1;
    localparam int XW   = (NUMW > DENW + 8) ? NUMW : DENW + 8;
    localparam logic [NW-1:0] AREA_C = NW'(AREA);

    localparam logic [3:0] CNT_M2    = 4'd0;
    localparam logic [3:0] CNT_M3    = 4'd1;
    localparam logic [3:0] CNT_SUM   = 4'd2;
    localparam logic [3:0] CNT_CHECK = 4'd3;
    localparam logic [3:0] CNT_DIV   = 4'd4;
    localparam logic [3:0] CNT_LAST  = 4'd11;

    logic [SW-1:0]   row_s, r_s;
    logic [S2W-1:0]  row_s2, r_s2;
    logic [VW-1:0]   r_ns2, r_sq, r_v;
    logic [SNW-1:0]  r_sn;
    logic [SNSW-1:0] r_sns;
    logic [SNNW-1:0] r_snn;
    logic [VCW-1:0]  r_vc;
    logic [DENW-1:0] r_den;
    logic [NUMW-1:0] r_num;
    logic [XW-1:0]   r_rem, den_sh;
    logic [7:0]      r_c, r_q;
    logic            r_ovr, r_busy, r_done;
    logic [3:0]      r_cnt;
    logic [2:0]      bit_idx;

    always_comb begin
        logic [7:0] px;
        row_s  = '0;
        row_s2 = '0;
        for (int k = 0; k < WINDOW; k++) begin
            px     = i_row[k*8 +: 8];
            row_s  = row_s + SW'(px);
            row_s2 = row_s2 + S2W'({8'd0, px} * {8'd0, px});
        end
    end

    assign bit_idx = 3'(CNT_LAST - r_cnt);
    assign den_sh  = XW'(r_den) << bit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            r_s  <= (i_ctl.acc_first ? '0 : r_s) + row_s;
            r_s2 <= (i_ctl.acc_first ? '0 : r_s2) + row_s2;
        end
        if (i_ctl.start) begin
            r_ns2 <= VW'(r_s2) * VW'(AREA_C);
            r_sq  <= VW'(r_s) * VW'(r_s);
            r_sn  <= SNW'(i_sigma) * SNW'(AREA_C);
            r_c   <= i_centre;
        end else if (r_busy) begin
            case (r_cnt)
                CNT_M2: begin
                    r_v   <= r_ns2 - r_sq;
                    r_sns <= SNSW'(r_sn) * SNSW'(r_s);
                    r_snn <= SNNW'(r_sn) * SNNW'(AREA_C);
                end
                CNT_M3: begin
                    r_vc  <= VCW'(r_v) * VCW'(r_c);
                    r_den <= DENW'(r_v) + DENW'(r_snn);
                end
                CNT_SUM: begin
                    r_num <= NUMW'(r_sns) + NUMW'(r_vc);
                end
                CNT_CHECK: begin
                    r_rem <= XW'(r_num);
                    if (r_den == '0) begin
                        r_ovr <= 1'b1;
                        r_q   <= r_c;
                    end else if (XW'(r_num) >= (XW'(r_den) << 8)) begin
                        r_ovr <= 1'b1;
                        r_q   <= 8'hFF;
                    end else begin
                        r_ovr <= 1'b0;
                        r_q   <= 8'd0;
                    end
                end
                default: begin
                    if (!r_ovr && r_rem >= den_sh) begin
                        r_rem          <= r_rem - den_sh;
                        r_q[bit_idx]   <= 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_q;

    `LADF_ASSERT(a_start_idle, i_clk, i_rst_n, !i_ctl.start || !r_busy, "start while busy")
    `LADF_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done longer than one cycle")
    `LADF_ASSERT(a_rem_bound, i_clk, i_rst_n, !(r_busy && r_cnt >= CNT_DIV && !r_ovr) || (r_rem < (XW'(r_den) << 8)), "remainder out of range")
endmodule

// File: design/lee_adaptive_denoise_filter_core.sv
// Lee filter over a raster pixel stream, one or three 8-bit channels. One word in is one
// pixel; one word out is the filtered centre of a WINDOW x WINDOW window lying wholly in
// the frame, so border pixels give no word. A border pixel passes through accept, line
// store read and window shift; for an interior pixel the window sums are then gathered
// one window row per cycle, then each channel lane runs a fixed 12-step sequence of
// multiplies ending in an 8-step restoring divide. The three channel lanes run side by side.
// A finished word waits in the output register while the next pixel is taken.
// Configuration must be written only while the block is idle; the block does not enforce it.
`include "lee_adaptive_denoise_filter_core_assert.svh"
module lee_adaptive_denoise_filter_core #(
    parameter int WINDOW    = 5,
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // sample_a, sample_b, sample_c
    input  logic        i_s_tuser,   // frame_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // pixel_col, pixel_row, result_a, result_b, result_c
    output logic        o_m_tlast,   // frame_done
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ladf_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int ROWS   = WINDOW - 1;
    localparam int SLW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW     = $clog2(WINDOW);
    localparam int CENTRE = WINDOW / 2;
    localparam int OFS    = WINDOW - 1 - CENTRE;

    t_state          r_state, n_state;
    t_lane_ctl       ctl;
    logic            ram_re, ram_we, load_out, out_free, interior;
    logic [2:0]      lane_done;
    logic [7:0]      lane_q [3];

    logic [15:0]     r_sigma;
    logic [11:0]     r_fw;
    logic [12:0]     r_fh;
    logic            r_three;

    logic [13:0]     w_eff;
    logic [12:0]     h_eff;
    logic [CW-1:0]   r_col, r_cur_col, acc_col;
    logic [11:0]     r_row, r_cur_row, acc_row;
    logic [SLW-1:0]  r_slot, r_cur_slot, acc_slot;
    logic [23:0]     r_pix;
    logic [AW-1:0]   r_acc_row;
    logic [WINDOW*24-1:0] r_win [WINDOW];
    logic [23:0]     rdata [ROWS];
    logic [23:0]     column [WINDOW];
    logic            r_ovalid;
    logic [47:0]     r_odata;
    logic            r_olast;

    assign w_eff = (r_fw == 12'd0) ? 14'd1 :
                   (14'(r_fw) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(r_fw);
    assign h_eff = (r_fh == 13'd0) ? 13'd1 :
                   (r_fh > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : r_fh;

    always_comb begin
        acc_col  = i_s_tuser ? '0 : r_col;
        acc_row  = i_s_tuser ? '0 : r_row;
        acc_slot = i_s_tuser ? '0 : r_slot;
        if (14'(acc_col) >= w_eff) begin
            acc_col = '0;
        end
        if (13'(acc_row) >= h_eff) begin
            acc_row  = '0;
            acc_slot = '0;
        end
    end

    assign interior = (14'(r_cur_col) >= 14'(WINDOW - 1)) &&
                      (12'(r_cur_row) >= 12'(WINDOW - 1));
    assign out_free = !r_ovalid || i_m_tready;

    always_comb begin
        logic [SLW:0] sel;
        for (int k = 0; k < ROWS; k++) begin
            sel = (SLW+1)'(r_cur_slot) + (SLW+1)'(k);
            if (sel >= (SLW+1)'(ROWS)) begin
                sel = sel - (SLW+1)'(ROWS);
            end
            column[k] = rdata[sel[SLW-1:0]];
        end
        column[WINDOW-1] = r_pix;
    end

    for (genvar g = 0; g < ROWS; g++) begin : g_line
        ladf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line (
            .i_clk   (i_clk),
            .i_we    (ram_we && (r_cur_slot == SLW'(g))),
            .i_waddr (r_cur_col),
            .i_wdata (r_pix),
            .i_re    (ram_re),
            .i_raddr (r_cur_col),
            .o_rdata (rdata[g])
        );
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic [WINDOW*8-1:0] row_px;
        always_comb begin
            for (int k = 0; k < WINDOW; k++) begin
                row_px[k*8 +: 8] = r_win[r_acc_row][k*24 + ch*8 +: 8];
            end
        end
        ladf_lane #(.WINDOW(WINDOW)) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_sigma  (r_sigma),
            .i_row    (row_px),
            .i_centre (r_win[CENTRE][CENTRE*24 + ch*8 +: 8]),
            .o_done   (lane_done[ch]),
            .o_result (lane_q[ch])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = S_RD;
            S_RD:    n_state = S_SHIFT;
            S_SHIFT: n_state = interior ? S_ACC : S_IDLE;
            S_ACC:   if (r_acc_row == AW'(WINDOW - 1)) n_state = S_START;
            S_START: n_state = S_CALC;
            S_CALC:  if (lane_done[0]) n_state = out_free ? S_IDLE : S_HOLD;
            S_HOLD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        ctl           = '0;
        load_out      = 1'b0;
        case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_RD:    ram_re = 1'b1;
            S_SHIFT: ram_we = 1'b1;
            S_ACC: begin
                ctl.acc_en    = 1'b1;
                ctl.acc_first = (r_acc_row == '0);
            end
            S_START: ctl.start = 1'b1;
            S_CALC:  load_out = lane_done[0] && out_free;
            S_HOLD:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sigma   <= 16'd100;
            r_fw      <= 12'd640;
            r_fh      <= 13'd480;
            r_three   <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_slot    <= '0;
            r_acc_row <= '0;
            r_ovalid  <= 1'b0;
            for (int r = 0; r < WINDOW; r++) begin
                r_win[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SIGMA:        r_sigma <= i_cfg_data;
                    CFG_FRAME_WIDTH:  r_fw    <= i_cfg_data[11:0];
                    CFG_FRAME_HEIGHT: r_fh    <= i_cfg_data[12:0];
                    CFG_THREE_CH:     r_three <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (ram_we) begin
                for (int r = 0; r < WINDOW; r++) begin
                    r_win[r] <= {column[r], r_win[r][WINDOW*24-1:24]};
                end
                if (14'(r_cur_col) + 14'd1 >= w_eff) begin
                    r_col <= '0;
                    if (13'(r_cur_row) + 13'd1 >= h_eff) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_cur_row + 12'd1;
                        r_slot <= (r_cur_slot == SLW'(ROWS - 1)) ? '0 : r_cur_slot + SLW'(1);
                    end
                end else begin
                    r_col  <= r_cur_col + CW'(1);
                    r_row  <= r_cur_row;
                    r_slot <= r_cur_slot;
                end
            end
            r_acc_row <= ctl.acc_en ? r_acc_row + AW'(1) : '0;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cur_col  <= acc_col;
            r_cur_row  <= acc_row;
            r_cur_slot <= acc_slot;
            r_pix      <= i_s_tdata;
        end
        if (load_out) begin
            r_odata <= {1'b0,
                        r_three ? lane_q[2] : 8'd0,
                        r_three ? lane_q[1] : 8'd0,
                        lane_q[0],
                        12'(r_cur_row - 12'(OFS)),
                        11'(r_cur_col - CW'(OFS))};
            r_olast <= (14'(r_cur_col) == w_eff - 14'd1) &&
                       (13'(r_cur_row) == h_eff - 13'd1);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    `LADF_ASSERT(a_done_in_calc, i_clk, i_rst_n, !lane_done[0] || r_state == S_CALC, "lane done outside calc")
    `LADF_ASSERT(a_lanes_agree, i_clk, i_rst_n, lane_done[0] == lane_done[1] && lane_done[0] == lane_done[2], "lanes out of step")
    `LADF_ASSERT_NEXT(a_interior_acc, i_clk, i_rst_n, r_state == S_SHIFT && interior, r_state == S_ACC, "interior pixel not filtered")
endmodule
